// ----- sv/bchd_pkg.sv -----
// ----------------------------------------------------------------------------
// bchd_pkg
// GF(64) arithmetic, tables and pipeline item type for the BCH t=3 decoder
// ----------------------------------------------------------------------------
package bchd_pkg;

    localparam int WORD_W      = 48;
    localparam int FIELD_ORDER = 63;
    localparam int MAX_SYN     = 8;
    localparam logic [6:0] GF_POLY = 7'b1011011;
    localparam logic [5:0] GF_TOP  = 6'd32;

    typedef logic [5:0] gf_t;
    typedef gf_t gf_tab_t [64];

    // how a word is being handled
    localparam logic [1:0] PATH_ZERO = 2'd0;
    localparam logic [1:0] PATH_ONE  = 2'd1;
    localparam logic [1:0] PATH_BAD  = 2'd2;
    localparam logic [1:0] PATH_BM   = 2'd3;

    localparam logic [1:0] STAT_CLEAN = 2'd0;
    localparam logic [1:0] STAT_FIXED = 2'd1;
    localparam logic [1:0] STAT_FAIL  = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0]            word;
        logic [WORD_W-1:0]            fix;
        logic [1:0]                   path;
        logic [MAX_SYN:0][5:0]        syn;
        gf_t                          sq;
        logic [MAX_SYN:0][5:0]        c;
        logic [MAX_SYN:0][5:0]        bp;
        logic [MAX_SYN:0][5:0]        p;
        logic [3:0]                   len;
        logic [3:0]                   m;
        gf_t                          bd;
        gf_t                          d;
        logic [FIELD_ORDER-1:0]       roots;
        logic [7:0][3:0]              part;
        logic                         bad;
    } bchd_item_t;

    function automatic gf_t gf_mul(gf_t a, gf_t b);
        gf_t r;
        gf_t x;
        gf_t y;
        r = '0;
        x = a;
        y = b;
        for (int k = 0; k < 6; k++)
        begin
            if (y[0])
                r = r ^ x;
            y = y >> 1;
            if ((x & GF_TOP) != 6'd0)
                x = (x << 1) ^ GF_POLY[5:0];
            else
                x = x << 1;
        end
        return r;
    endfunction

    function automatic gf_tab_t build_alpha();
        gf_tab_t t;
        t[0] = 6'd1;
        for (int k = 1; k < 64; k++)
            t[k] = gf_mul(t[k-1], 6'd2);
        return t;
    endfunction

    function automatic gf_tab_t build_inv();
        gf_tab_t t;
        gf_t r;
        for (int a = 0; a < 64; a++)
        begin
            r = 6'd1;
            for (int k = 0; k < FIELD_ORDER - 1; k++)
                r = gf_mul(r, 6'(a));
            t[a] = r;
        end
        return t;
    endfunction

    // log of x, smallest exponent wins; zero and unreachable values map to 63
    function automatic gf_tab_t build_log();
        gf_tab_t t;
        gf_t p;
        for (int a = 0; a < 64; a++)
            t[a] = 6'd63;
        p = 6'd1;
        for (int k = 0; k < FIELD_ORDER; k++)
        begin
            if (t[p] == 6'd63)
                t[p] = 6'(k);
            p = gf_mul(p, 6'd2);
        end
        return t;
    endfunction

    localparam gf_tab_t ALPHA   = build_alpha();
    localparam gf_tab_t INV_TAB = build_inv();
    localparam gf_tab_t LOG_TAB = build_log();

endpackage

// ----- sv/bch_t3_gf64_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// bch_t3_gf64_decoder_unit
// shortened binary BCH decoder over GF(64): syndromes, Berlekamp, Chien search
// ----------------------------------------------------------------------------
// register stages in order: syndromes, square, select, locator steps, chien, counts, output
// throughput: one word per cycle; the whole pipeline holds while out_valid is
//   high and out_ready is low
// every step of the locator iteration is its own pair of register stages
// reset clears all valid bits; data registers are not reset
module bch_t3_gf64_decoder_unit #(
    parameter int CODE_LENGTH        = 48,
    parameter int CORRECTABLE_ERRORS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] received_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] corrected_word,
    output logic [1:0]  decode_status,
    output logic [1:0]  errors_fixed
);

    localparam int NSYN = 2 * CORRECTABLE_ERRORS;
    localparam int N    = CODE_LENGTH;

    logic adv;

    logic                 syn_vld_reg, sq_vld_reg, sel_vld_reg, ch_vld_reg, cnt_vld_reg;
    bchd_pkg::bchd_item_t syn_reg, sq_reg, sel_reg, ch_reg, cnt_reg;
    bchd_pkg::bchd_item_t syn_next, sq_next, sel_next, ch_next, cnt_next;

    logic                 out_vld_reg;
    logic [47:0]          word_out_reg, word_out_next;
    logic [1:0]           status_reg, status_next;
    logic [1:0]           fixed_reg, fixed_next;

    logic                 bm_vld [NSYN+1];
    bchd_pkg::bchd_item_t bm_item [NSYN+1];

    assign adv      = !out_vld_reg || out_ready;
    assign in_ready = adv;

    // syndromes as a fixed xor map of the word bits
    always_comb
    begin
        bchd_pkg::gf_t acc;
        syn_next      = '0;
        syn_next.word = received_word;
        for (int i = 1; i <= NSYN; i++)
        begin
            acc = '0;
            for (int j = 0; j < N; j++)
            begin
                if (received_word[j])
                    acc = acc ^ bchd_pkg::ALPHA[6'((i * (N - 1 - j)) % 63)];
            end
            syn_next.syn[i] = acc;
        end
    end

    always_comb
    begin
        logic any;
        sq_next = syn_reg;
        any = 1'b0;
        for (int i = 1; i <= NSYN; i++)
            any = any | (syn_reg.syn[i] != 6'd0);
        sq_next.path = any ? bchd_pkg::PATH_BM : bchd_pkg::PATH_ZERO;
        sq_next.sq   = bchd_pkg::gf_mul(syn_reg.syn[1], syn_reg.syn[1]);
    end

    // single error shortcut and locator init
    always_comb
    begin
        bchd_pkg::gf_t cube;
        bchd_pkg::gf_t loc;
        sel_next = sq_reg;
        cube = bchd_pkg::gf_mul(sq_reg.sq, sq_reg.syn[1]);
        loc  = bchd_pkg::LOG_TAB[sq_reg.syn[1]];
        if (sq_reg.path == bchd_pkg::PATH_BM && sq_reg.syn[1] != 6'd0
            && sq_reg.syn[3] == cube)
        begin
            if (loc < 6'(N))
            begin
                sel_next.path = bchd_pkg::PATH_ONE;
                sel_next.fix  = 48'(1) << (6'(N - 1) - loc);
            end
            else
            begin
                sel_next.path = bchd_pkg::PATH_BAD;
            end
        end
        sel_next.c     = '0;
        sel_next.c[0]  = 6'd1;
        sel_next.bp    = '0;
        sel_next.bp[0] = 6'd1;
        sel_next.len   = 4'd0;
        sel_next.m     = 4'd1;
        sel_next.bd    = 6'd1;
    end

    assign bm_vld[0]  = sel_vld_reg;
    assign bm_item[0] = sel_reg;

    genvar gs;
    generate
        for (gs = 0; gs < NSYN; gs++)
        begin : g_bm
            bchd_bm_step #(
                .STEP (gs),
                .NSYN (NSYN)
            ) u_step (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (adv),
                .in_vld   (bm_vld[gs]),
                .in_item  (bm_item[gs]),
                .out_vld  (bm_vld[gs+1]),
                .out_item (bm_item[gs+1])
            );
        end
    endgenerate

    // chien search, all 63 nonzero points in parallel
    always_comb
    begin
        bchd_pkg::gf_t v;
        ch_next = bm_item[NSYN];
        for (int i = 1; i <= 63; i++)
        begin
            v = '0;
            for (int j = 0; j <= CORRECTABLE_ERRORS; j++)
            begin
                if (4'(j) <= bm_item[NSYN].len)
                    v = v ^ bchd_pkg::gf_mul(bm_item[NSYN].c[j],
                                             bchd_pkg::ALPHA[6'((i * j) % 63)]);
            end
            ch_next.roots[i-1] = (v == 6'd0);
        end
    end

    // partial root counts, range check, flip mask
    always_comb
    begin
        logic [3:0] sum;
        cnt_next = ch_reg;
        for (int g = 0; g < 8; g++)
        begin
            sum = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (g * 8 + k < 63)
                    sum = sum + 4'(ch_reg.roots[g*8+k]);
            end
            cnt_next.part[g] = sum;
        end
        cnt_next.bad = 1'b0;
        for (int i = 1; i <= 63 - N; i++)
            cnt_next.bad = cnt_next.bad | ch_reg.roots[i-1];
        if (ch_reg.path == bchd_pkg::PATH_BM)
        begin
            cnt_next.fix = '0;
            for (int k = 0; k < N; k++)
                cnt_next.fix[k] = ch_reg.roots[k + 63 - N];
        end
    end

    always_comb
    begin
        logic [6:0] cnt;
        cnt = '0;
        for (int g = 0; g < 8; g++)
            cnt = cnt + 7'(cnt_reg.part[g]);
        word_out_next = cnt_reg.word;
        status_next   = bchd_pkg::STAT_FAIL;
        fixed_next    = 2'd0;
        unique case (cnt_reg.path)
            bchd_pkg::PATH_ZERO:
            begin
                status_next = bchd_pkg::STAT_CLEAN;
            end
            bchd_pkg::PATH_ONE:
            begin
                status_next   = bchd_pkg::STAT_FIXED;
                fixed_next    = 2'd1;
                word_out_next = cnt_reg.word ^ cnt_reg.fix;
            end
            bchd_pkg::PATH_BAD:
            begin
                status_next = bchd_pkg::STAT_FAIL;
            end
            bchd_pkg::PATH_BM:
            begin
                if (cnt_reg.len <= 4'(CORRECTABLE_ERRORS) && !cnt_reg.bad
                    && cnt == {3'b0, cnt_reg.len})
                begin
                    status_next   = bchd_pkg::STAT_FIXED;
                    fixed_next    = cnt[1:0];
                    word_out_next = cnt_reg.word ^ cnt_reg.fix;
                end
            end
            default:
            begin
                status_next = bchd_pkg::STAT_FAIL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_vld_reg <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sel_vld_reg <= 1'b0;
            ch_vld_reg  <= 1'b0;
            cnt_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            syn_vld_reg <= in_valid;
            sq_vld_reg  <= syn_vld_reg;
            sel_vld_reg <= sq_vld_reg;
            ch_vld_reg  <= bm_vld[NSYN];
            cnt_vld_reg <= ch_vld_reg;
            out_vld_reg <= cnt_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            syn_reg      <= syn_next;
            sq_reg       <= sq_next;
            sel_reg      <= sel_next;
            ch_reg       <= ch_next;
            cnt_reg      <= cnt_next;
            word_out_reg <= word_out_next;
            status_reg   <= status_next;
            fixed_reg    <= fixed_next;
        end
    end

    assign out_valid      = out_vld_reg;
    assign corrected_word = word_out_reg;
    assign decode_status  = status_reg;
    assign errors_fixed   = fixed_reg;

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (decode_status != 2'd3))
        else $error("illegal decode status");

    a_no_fix_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decode_status != bchd_pkg::STAT_FIXED |-> errors_fixed == 2'd0)
        else $error("flip count on unrepaired word");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(cnt_vld_reg) && $stable(ch_vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ----- sv/bchd_bm_step.sv -----
// ----------------------------------------------------------------------------
// bchd_bm_step
// one Berlekamp iteration in two register stages: discrepancy, then update
// ----------------------------------------------------------------------------
module bchd_bm_step #(
    parameter int STEP = 0,
    parameter int NSYN = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  bchd_pkg::bchd_item_t in_item,
    output logic                out_vld,
    output bchd_pkg::bchd_item_t out_item
);

    logic                 a_vld_reg;
    bchd_pkg::bchd_item_t a_reg;
    bchd_pkg::bchd_item_t a_next;
    logic                 b_vld_reg;
    bchd_pkg::bchd_item_t b_reg;
    bchd_pkg::bchd_item_t b_next;

    // discrepancy and B scaled by 1/b
    always_comb
    begin
        bchd_pkg::gf_t dd;
        bchd_pkg::gf_t invb;
        a_next = in_item;
        dd = in_item.syn[STEP+1];
        for (int j = 1; j <= STEP; j++)
        begin
            if (4'(j) <= in_item.len)
                dd = dd ^ bchd_pkg::gf_mul(in_item.c[j], in_item.syn[STEP+1-j]);
        end
        invb = bchd_pkg::INV_TAB[in_item.bd];
        for (int j = 0; j <= NSYN; j++)
            a_next.p[j] = bchd_pkg::gf_mul(invb, in_item.bp[j]);
        a_next.d = dd;
    end

    // locator update
    always_comb
    begin
        logic [bchd_pkg::MAX_SYN:0][5:0] ps;
        b_next = a_reg;
        ps = '0;
        for (int k = 0; k <= NSYN; k++)
        begin
            for (int s = 1; s <= NSYN; s++)
            begin
                if (k >= s)
                begin
                    if (a_reg.m == 4'(s))
                        ps[k] = a_reg.p[k-s];
                end
            end
        end
        if (a_reg.d == 6'd0)
        begin
            b_next.m = a_reg.m + 4'd1;
        end
        else
        begin
            for (int k = 0; k <= NSYN; k++)
                b_next.c[k] = a_reg.c[k] ^ bchd_pkg::gf_mul(a_reg.d, ps[k]);
            if ({a_reg.len, 1'b0} <= 5'(STEP))
            begin
                b_next.len = 4'(STEP + 1) - a_reg.len;
                b_next.bp  = a_reg.c;
                b_next.bd  = a_reg.d;
                b_next.m   = 4'd1;
            end
            else
            begin
                b_next.m = a_reg.m + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign out_vld  = b_vld_reg;
    assign out_item = b_reg;

endmodule
